// ===== rtl/shannon_entropy_of_counts_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Shannon entropy core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SHANNON_ENTROPY_OF_COUNTS_CORE_ASSERT_SVH
`define SHANNON_ENTROPY_OF_COUNTS_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// General property, checked at every clock edge out of reset
`define SEOC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never hold out of reset
`define SEOC_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define SEOC_ASSERT(lbl, clk, rstn, prop, msg)
`define SEOC_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== rtl/seoc_pkg.sv =====
// ----------------------------------------------------------------------------
// seoc_pkg
// Types and fixed constants shared by the Shannon entropy core.
// ----------------------------------------------------------------------------
package seoc_pkg;

  localparam int CNT_W          = 32;  // count and total port width
  localparam int LOG_W          = 22;  // Q.16 logarithm, leading-one position above
  localparam int FRAC_BITS      = 16;
  localparam int LOG_EXTRA_BITS = 40;  // bits found by squaring before rounding
  localparam int TERM_W         = CNT_W + LOG_W;
  localparam int ACC_W          = 64;
  localparam int ENT_W          = 22;
  localparam logic [ENT_W-1:0] ENTROPY_MAX = '1;

  localparam int QUEUE_DEPTH = 4;      // power of two
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ENT_TERM,
    ENT_SKIP,
    ENT_TOTAL
  } ent_kind_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [ENT_W-1:0] entropy;
    logic             count_over_total;
    logic             sum_saturated;
  } out_t;

  // Classified work between the front and the back
  typedef struct packed {
    ent_kind_e        kind;
    logic             last;
    logic             over;
    logic [CNT_W-1:0] value;
    logic [LOG_W-1:0] log;
  } ent_t;

  typedef struct packed {
    logic push;
    ent_t ent;
  } q_wr_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
    logic             over;
    logic             sat;
  } div_cmd_t;

endpackage

// ===== rtl/seoc_front.sv =====
// ----------------------------------------------------------------------------
// seoc_front
// Accepts counts and total writes, classifies them and computes their Q.16
// logarithm in four stages: capture, leading-one search, normalise, table.
// ----------------------------------------------------------------------------
module seoc_front #(
  parameter int COUNT_WIDTH    = 32,
  parameter int LOG_TABLE_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  seoc_pkg::in_t                in_item_i,
  output logic                         full_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [seoc_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic                         q_full_i,
  output seoc_pkg::q_wr_t              q_wr_o
);

  localparam int CntW      = (COUNT_WIDTH < seoc_pkg::CNT_W) ? COUNT_WIDTH : seoc_pkg::CNT_W;
  localparam int PosW      = $clog2(CntW);
  localparam int TableSize = 2 ** LOG_TABLE_BITS;
  localparam int RomW      = seoc_pkg::FRAC_BITS;
  localparam int ExtraW    = seoc_pkg::LOG_EXTRA_BITS;

  // Word k is round(2^16 * log2(1 + k / TableSize)), by repeated squaring
  function automatic logic [TableSize*RomW-1:0] build_rom();
    logic [TableSize*RomW-1:0] rom;
    logic [63:0]               m;
    logic [127:0]              prod;
    logic [ExtraW:0]           bits;
    rom = '0;
    for (int k = 0; k < TableSize; k++) begin
      m    = 64'(TableSize + k) << (63 - LOG_TABLE_BITS);
      bits = '0;
      for (int i = 0; i < ExtraW; i++) begin
        prod = {64'd0, m} * {64'd0, m};
        bits = bits << 1;
        if (prod[127]) begin
          bits[0] = 1'b1;
          m       = prod[127:64];
        end else begin
          m = prod[126:63];
        end
      end
      bits = bits + ((ExtraW + 1)'(1) << (ExtraW - RomW - 1));
      rom[k*RomW +: RomW] = bits[ExtraW-1 -: RomW];
    end
    return rom;
  endfunction

  localparam logic [TableSize*RomW-1:0] LogRom = build_rom();

  typedef struct packed {
    seoc_pkg::ent_kind_e       kind;
    logic                      last;
    logic                      over;
    logic                      zero;
    logic [CntW-1:0]           val;
    logic [PosW-1:0]           pos;
    logic [LOG_TABLE_BITS-1:0] idx;
  } stage_t;

  logic                      front_en;
  logic                      in_acc;
  logic                      cfg_acc;
  logic [CntW-1:0]           total_q;
  logic [CntW-1:0]           in_val;
  logic                      s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  stage_t                    s1_d, s1_q, s2_d, s2_q, s3_d, s3_q, s4_q;
  logic [PosW-1:0]           lead;
  logic [PosW-1:0]           shift_amt;
  logic [CntW-1:0]           norm;
  logic [CntW+LOG_TABLE_BITS-1:0] ext;
  logic [RomW-1:0]           rom_q;

  // The whole pipe holds while its last stage cannot hand over
  assign front_en    = !s4_valid_q || !q_full_i;
  assign cfg_ready_o = front_en;
  assign full_o      = !front_en || cfg_valid_i;
  assign in_acc      = push_i && !full_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_val      = in_item_i.count[CntW-1:0];

  always_comb begin
    s1_d = '0;
    if (cfg_acc) begin
      s1_d.kind = seoc_pkg::ENT_TOTAL;
      s1_d.val  = cfg_data_i[CntW-1:0];
    end else begin
      s1_d.val  = in_val;
      s1_d.last = in_item_i.last;
      priority if (in_val == '0) begin
        s1_d.kind = seoc_pkg::ENT_SKIP;
      end else if (in_val > total_q) begin
        s1_d.kind = seoc_pkg::ENT_SKIP;
        s1_d.over = 1'b1;
      end else begin
        s1_d.kind = seoc_pkg::ENT_TERM;
      end
    end
  end

  always_comb begin
    lead = '0;
    for (int i = 0; i < CntW; i++) begin
      if (s1_q.val[i]) begin
        lead = PosW'(i);
      end
    end
    s2_d      = s1_q;
    s2_d.pos  = lead;
    s2_d.zero = (s1_q.val == '0);
  end

  // Bring the leading one to the top; the table index is the bits below it
  always_comb begin
    shift_amt = PosW'(CntW - 1) - s2_q.pos;
    norm      = s2_q.val << shift_amt;
    ext       = {norm, {LOG_TABLE_BITS{1'b0}}};
    s3_d      = s2_q;
    s3_d.idx  = ext[CntW+LOG_TABLE_BITS-2 -: LOG_TABLE_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      total_q    <= '0;
    end else begin
      if (cfg_acc) begin
        total_q <= cfg_data_i[CntW-1:0];
      end
      if (front_en) begin
        s1_valid_q <= in_acc || cfg_acc;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s3_q;
      rom_q <= LogRom[s3_q.idx*RomW +: RomW];
    end
  end

  always_comb begin
    q_wr_o           = '0;
    q_wr_o.push      = s4_valid_q && !q_full_i;
    q_wr_o.ent.kind  = s4_q.kind;
    q_wr_o.ent.last  = s4_q.last;
    q_wr_o.ent.over  = s4_q.over;
    q_wr_o.ent.value = seoc_pkg::CNT_W'(s4_q.val);
    q_wr_o.ent.log   = s4_q.zero ? '0 : seoc_pkg::LOG_W'({s4_q.pos, rom_q});
  end

endmodule

// ===== rtl/seoc_queue.sv =====
// ----------------------------------------------------------------------------
// seoc_queue
// Short first-in first-out queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module seoc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  seoc_pkg::q_wr_t wr_i,
  output logic            full_o,
  output logic            rd_valid_o,
  output seoc_pkg::ent_t  rd_ent_o,
  input  logic            pop_i
);

  seoc_pkg::ent_t                 slots_q [seoc_pkg::QUEUE_DEPTH];
  logic [seoc_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [seoc_pkg::QCNT_W-1:0]    fill_q;
  logic                           push_ok, pop_ok;

  assign full_o     = (fill_q == seoc_pkg::QCNT_W'(seoc_pkg::QUEUE_DEPTH));
  assign rd_valid_o = (fill_q != '0);
  assign rd_ent_o   = slots_q[rd_ptr_q];
  assign push_ok    = wr_i.push && !full_o;
  assign pop_ok     = pop_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      priority if (push_ok && !pop_ok) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_ok && !push_ok) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slots_q[wr_ptr_q] <= wr_i.ent;
    end
  end

endmodule

// ===== rtl/seoc_back.sv =====
// ----------------------------------------------------------------------------
// seoc_back
// Multiplies each count by its log difference and adds the term to a
// saturating accumulator; hands the sum of a finished table to the divider.
// ----------------------------------------------------------------------------
module seoc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_valid_i,
  input  seoc_pkg::ent_t      rd_ent_i,
  output logic                pop_o,
  input  logic                div_busy_i,
  output seoc_pkg::div_cmd_t  div_cmd_o
);

  typedef struct packed {
    seoc_pkg::ent_kind_e               kind;
    logic                              last;
    logic                              over;
    logic [seoc_pkg::CNT_W-1:0]        value;
    logic [seoc_pkg::TERM_W-1:0]       term;
  } mul_t;

  logic                         m_valid_q;
  mul_t                         m_q, m_d;
  logic                         m_consume, m_ready;
  logic [seoc_pkg::LOG_W-1:0]   log_total_q;
  logic [seoc_pkg::LOG_W-1:0]   diff;
  logic [seoc_pkg::TERM_W-1:0]  prod;
  logic [seoc_pkg::CNT_W-1:0]   total_q, total_d;
  logic [seoc_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic [seoc_pkg::ACC_W:0]     sum;
  logic                         sat_q, sat_d, over_q, over_d;

  // A table end waits in the multiply stage until the divider is free
  assign m_consume = m_valid_q && !(m_q.last && div_busy_i);
  assign m_ready   = !m_valid_q || m_consume;
  assign pop_o     = rd_valid_i && m_ready;

  always_comb begin
    diff = (log_total_q > rd_ent_i.log) ? (log_total_q - rd_ent_i.log) : '0;
    prod = rd_ent_i.value * diff;
    m_d       = '0;
    m_d.kind  = rd_ent_i.kind;
    m_d.last  = rd_ent_i.last;
    m_d.over  = rd_ent_i.over;
    m_d.value = rd_ent_i.value;
    m_d.term  = (rd_ent_i.kind == seoc_pkg::ENT_TERM) ? prod : '0;
  end

  always_comb begin
    acc_d   = acc_q;
    sat_d   = sat_q;
    over_d  = over_q;
    total_d = total_q;
    sum     = {1'b0, acc_q} + (seoc_pkg::ACC_W + 1)'(m_q.term);
    unique case (m_q.kind)
      seoc_pkg::ENT_TERM: begin
        if (sum[seoc_pkg::ACC_W]) begin
          acc_d = '1;
          sat_d = 1'b1;
        end else begin
          acc_d = sum[seoc_pkg::ACC_W-1:0];
        end
      end
      seoc_pkg::ENT_SKIP: begin
        over_d = over_q | m_q.over;
      end
      seoc_pkg::ENT_TOTAL: begin
        total_d = m_q.value;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_cmd_o.start    = m_consume && m_q.last;
    div_cmd_o.dividend = acc_d;
    div_cmd_o.divisor  = total_q;
    div_cmd_o.over     = over_d;
    div_cmd_o.sat      = sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      log_total_q <= '0;
      total_q     <= '0;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      over_q      <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid_q <= pop_o;
      end
      // The log of the total is needed by the very next entry's multiply
      if (pop_o && rd_ent_i.kind == seoc_pkg::ENT_TOTAL) begin
        log_total_q <= rd_ent_i.log;
      end
      if (m_consume) begin
        total_q <= total_d;
        if (m_q.last) begin
          acc_q  <= '0;
          sat_q  <= 1'b0;
          over_q <= 1'b0;
        end else begin
          acc_q  <= acc_d;
          sat_q  <= sat_d;
          over_q <= over_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m_q <= m_d;
    end
  end

endmodule

// ===== rtl/seoc_div.sv =====
// ----------------------------------------------------------------------------
// seoc_div
// Restoring divider, one quotient bit per cycle, clamping to the entropy
// range; holds the finished result until it is taken.
// ----------------------------------------------------------------------------
module seoc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  seoc_pkg::div_cmd_t cmd_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output seoc_pkg::out_t     res_o,
  input  logic               pop_i
);

  localparam int CntW = $clog2(seoc_pkg::ACC_W);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [seoc_pkg::ACC_W-1:0]   dvd_q, dvd_d;
  logic [seoc_pkg::CNT_W-1:0]   dsr_q, dsr_d;
  logic [seoc_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic [seoc_pkg::ENT_W-1:0]   quo_q, quo_d;
  logic                         ovf_q, ovf_d;
  logic                         over_q, over_d, sat_q, sat_d;
  logic [seoc_pkg::CNT_W:0]     rem_sh, rem_sub;
  logic                         ge;

  assign rem_sh  = {rem_q, dvd_q[seoc_pkg::ACC_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    over_d  = over_q;
    sat_d   = sat_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_i.start) begin
          dvd_d  = cmd_i.dividend;
          dsr_d  = cmd_i.divisor;
          over_d = cmd_i.over;
          sat_d  = cmd_i.sat;
          rem_d  = '0;
          quo_d  = '0;
          ovf_d  = 1'b0;
          cnt_d  = '0;
          // A zero total gives zero entropy straight away
          state_d = (cmd_i.divisor == '0) ? StDone : StRun;
        end
      end
      StRun: begin
        rem_d = ge ? rem_sub[seoc_pkg::CNT_W-1:0] : rem_sh[seoc_pkg::CNT_W-1:0];
        dvd_d = dvd_q << 1;
        quo_d = {quo_q[seoc_pkg::ENT_W-2:0], ge};
        // Any quotient bit leaving the top means the result is out of range
        ovf_d = ovf_q | quo_q[seoc_pkg::ENT_W-1];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(seoc_pkg::ACC_W - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (pop_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    over_q <= over_d;
    sat_q  <= sat_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign res_valid_o = (state_q == StDone);

  always_comb begin
    res_o.entropy          = ovf_q ? seoc_pkg::ENTROPY_MAX : quo_q;
    res_o.count_over_total = over_q;
    res_o.sum_saturated    = sat_q | ovf_q;
  end

endmodule

// ===== rtl/shannon_entropy_of_counts_core.sv =====
// ----------------------------------------------------------------------------
// shannon_entropy_of_counts_core
// Shannon entropy in bits (Q.16) of a frequency table streamed one count at
// a time, against a configured total token count.
// ----------------------------------------------------------------------------
// Write the total token count N on the cfg channel while the core is idle;
// full is also high while a cfg write is offered. Push one count per cycle
// (push/full), with last set on the table's final count. One result per
// table comes out on the empty/pop side: entropy, over-total and saturation.
// Counts are taken one per cycle while full is low, through a four-stage
// log pipeline, a four-entry queue and a registered multiply stage. A
// bit-serial divider then forms the quotient (skipped, giving zero, when N
// is zero), and the divider takes no new table until the previous result
// has been taken. Counts of the next table keep flowing meanwhile; its
// last count waits in the multiply stage until the previous result has
// been taken.
// Reset clears the total, the accumulator and its flags; the divider's
// result flags are not reset. If the receiver does not pop, the result
// holds and the input side backs up through the queue until full rises.
// ----------------------------------------------------------------------------
`include "shannon_entropy_of_counts_core_assert.svh"

module shannon_entropy_of_counts_core #(
  parameter int COUNT_WIDTH    = 32,
  parameter int LOG_TABLE_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  seoc_pkg::in_t               in_item_i,
  output logic                        empty,
  input  logic                        pop,
  output seoc_pkg::out_t              out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [seoc_pkg::CNT_W-1:0]  cfg_data_i
);

  seoc_pkg::q_wr_t    q_wr;
  logic               q_full;
  logic               q_rd_valid;
  seoc_pkg::ent_t     q_rd_ent;
  logic               q_pop;
  seoc_pkg::div_cmd_t div_cmd;
  logic               div_busy;
  logic               res_valid;

  seoc_front #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr)
  );

  seoc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .full_o     (q_full),
    .rd_valid_o (q_rd_valid),
    .rd_ent_o   (q_rd_ent),
    .pop_i      (q_pop)
  );

  seoc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (q_rd_valid),
    .rd_ent_i   (q_rd_ent),
    .pop_o      (q_pop),
    .div_busy_i (div_busy),
    .div_cmd_o  (div_cmd)
  );

  seoc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (div_cmd),
    .busy_o      (div_busy),
    .res_valid_o (res_valid),
    .res_o       (out_item_o),
    .pop_i       (pop)
  );

  assign empty = !res_valid;

  `SEOC_NEVER(a_queue_overrun, clk_i, rst_ni, q_wr.push && q_full, "transfer into a full queue")
  `SEOC_NEVER(a_div_start_busy, clk_i, rst_ni, div_cmd.start && div_busy, "divider restarted while busy")
  `SEOC_ASSERT(a_div_no_early_result, clk_i, rst_ni, (div_cmd.start && div_cmd.divisor != '0) |=> empty, "result shown before the division ran")

endmodule
